// ===== rtl/core/esc_thr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC throttle controller package
// Shared types, register map, command codes and fixed-point constants for the
// ESC pulse command unit with arm control and command-timeout failsafe.
// ----------------------------------------------------------------------------
package esc_thr_pkg;

  // Field widths.
  localparam int unsigned PulseW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ThrW   = 16;

  // Configuration port geometry.
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 4;

  // Reset values of the configuration registers.
  localparam logic [PulseW-1:0] PulseMinRst   = 16'd1000;
  localparam logic [PulseW-1:0] PulseMaxRst   = 16'd2000;
  localparam logic [TimeW-1:0]  CmdTimeoutRst = 32'd500;

  // Throttle scaling: full scale is 100.00 percent in hundredths.
  localparam int unsigned ThrFull  = 10000;
  localparam int unsigned ThrRound = 5000;
  localparam int unsigned ThrCW    = 14;   // clamped throttle 0..10000
  localparam int unsigned SpanW    = PulseW + 1;
  localparam int unsigned ProdW    = ThrCW + 1 + SpanW;
  localparam int unsigned NumW     = 30;   // numerator stays below 2^30
  localparam int unsigned SumW     = 33;

  // Division by 10000 as a shift by four, then a reciprocal multiply for 625.
  // The reciprocal is exact for every dividend below 2^26.
  localparam int unsigned DivPreShift = 4;
  localparam int unsigned DivInW      = NumW - DivPreShift;
  localparam int unsigned RecipW      = 27;
  localparam logic [RecipW-1:0] RecipMult = 27'd109951163;
  localparam int unsigned RecipShift  = 36;
  localparam int unsigned DivProdW    = DivInW + RecipW;
  localparam int unsigned QuotW       = PulseW + 1;

  // Command codes.
  typedef enum logic [CmdW-1:0] {
    CMD_ARM          = 3'd0,
    CMD_DISARM       = 3'd1,
    CMD_SET_THROTTLE = 3'd2,
    CMD_SET_PULSE    = 3'd3,
    CMD_TICK         = 3'd4
  } cmd_e;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_PULSE_MIN   = 2'd0,
    REG_PULSE_MAX   = 2'd1,
    REG_CMD_TIMEOUT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [PulseW-1:0] pulse_min_us;
    logic [PulseW-1:0] pulse_max_us;
    logic [TimeW-1:0]  cmd_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic              armed;
    logic [PulseW-1:0] target_us;
    logic [PulseW-1:0] output_us;
    logic [TimeW-1:0]  last_cmd_time;
  } state_t;

  // Item as held in the input register; the throttle arrives already turned
  // into the rounding numerator of the pulse mapping.
  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [TimeW-1:0]  now_ms;
    logic [NumW-1:0]   thr_num;
    logic [PulseW-1:0] pulse_req_us;
    logic              pwm_start_ok;
  } item_t;

  typedef struct packed {
    logic              armed_flag;
    logic [PulseW-1:0] pulse_out_us;
    logic              pulse_written;
    logic              pwm_start_req;
    logic              pwm_stop_req;
    logic              timed_out;
  } result_t;

  // Clamp a pulse into min..max, lower bound tested first.
  function automatic logic [PulseW-1:0] bound_pulse(input logic [PulseW-1:0] v,
                                                    input logic [PulseW-1:0] lo,
                                                    input logic [PulseW-1:0] hi);
    logic [PulseW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/esc_thr_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC throttle controller register file
// APB-style configuration registers: minimum pulse, maximum pulse and the
// command timeout, with read-back.
// ----------------------------------------------------------------------------
module esc_thr_regs #(
  parameter logic [esc_thr_pkg::PulseW-1:0] PulseMinRst   = esc_thr_pkg::PulseMinRst,
  parameter logic [esc_thr_pkg::PulseW-1:0] PulseMaxRst   = esc_thr_pkg::PulseMaxRst,
  parameter logic [esc_thr_pkg::TimeW-1:0]  CmdTimeoutRst = esc_thr_pkg::CmdTimeoutRst
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [esc_thr_pkg::AddrW-1:0]    paddr,
  input  logic [esc_thr_pkg::DataW-1:0]    pwdata,
  output logic [esc_thr_pkg::DataW-1:0]    prdata,
  output logic                             pready,
  output esc_thr_pkg::cfg_t                cfg_o
);

  esc_thr_pkg::cfg_t     cfg_q, cfg_d;
  esc_thr_pkg::reg_idx_e idx;
  logic                  wr_en;

  assign pready = 1'b1;
  assign idx    = esc_thr_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // Register write decode; an address beyond the map is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        esc_thr_pkg::REG_PULSE_MIN:   cfg_d.pulse_min_us   = pwdata[esc_thr_pkg::PulseW-1:0];
        esc_thr_pkg::REG_PULSE_MAX:   cfg_d.pulse_max_us   = pwdata[esc_thr_pkg::PulseW-1:0];
        esc_thr_pkg::REG_CMD_TIMEOUT: cfg_d.cmd_timeout_ms = pwdata[esc_thr_pkg::TimeW-1:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min_us   <= PulseMinRst;
      cfg_q.pulse_max_us   <= PulseMaxRst;
      cfg_q.cmd_timeout_ms <= CmdTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      esc_thr_pkg::REG_PULSE_MIN:   prdata = {16'd0, cfg_q.pulse_min_us};
      esc_thr_pkg::REG_PULSE_MAX:   prdata = {16'd0, cfg_q.pulse_max_us};
      esc_thr_pkg::REG_CMD_TIMEOUT: prdata = cfg_q.cmd_timeout_ms;
      default:                      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/esc_thr_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC throttle controller update logic
// Works out the next controller state and the result of one registered item:
// arm, disarm, throttle and pulse commands and the failsafe tick.
// ----------------------------------------------------------------------------
module esc_thr_update (
  input  esc_thr_pkg::cfg_t    cfg_i,
  input  esc_thr_pkg::state_t  state_i,
  input  esc_thr_pkg::item_t   item_i,
  output esc_thr_pkg::state_t  state_o,
  output esc_thr_pkg::result_t result_o
);

  logic [esc_thr_pkg::DivProdW-1:0] div_prod;
  logic [esc_thr_pkg::QuotW-1:0]    quot;
  logic [esc_thr_pkg::PulseW-1:0]   thr_pulse;
  logic [esc_thr_pkg::PulseW-1:0]   req_pulse;
  logic [esc_thr_pkg::TimeW-1:0]    elapsed;
  logic                             expired;

  // Divide the rounding numerator by 10000 and saturate to the pulse width.
  assign div_prod = esc_thr_pkg::DivProdW'(
                      item_i.thr_num[esc_thr_pkg::NumW-1:esc_thr_pkg::DivPreShift])
                    * esc_thr_pkg::DivProdW'(esc_thr_pkg::RecipMult);
  assign quot     = div_prod[esc_thr_pkg::RecipShift +: esc_thr_pkg::QuotW];
  assign thr_pulse = quot[esc_thr_pkg::QuotW-1] ? {esc_thr_pkg::PulseW{1'b1}}
                                                : quot[esc_thr_pkg::PulseW-1:0];

  assign req_pulse = esc_thr_pkg::bound_pulse(item_i.pulse_req_us, cfg_i.pulse_min_us,
                                              cfg_i.pulse_max_us);

  // Wrapping time since the last command, compared with the timeout.
  assign elapsed = item_i.now_ms - state_i.last_cmd_time;
  assign expired = elapsed > cfg_i.cmd_timeout_ms;

  // Command decode and state update.
  always_comb begin
    esc_thr_pkg::cmd_e cmd;
    cmd      = esc_thr_pkg::cmd_e'(item_i.command);
    state_o  = state_i;
    result_o = '0;
    case (cmd)
      esc_thr_pkg::CMD_ARM: begin
        result_o.pwm_start_req = 1'b1;
        if (item_i.pwm_start_ok) begin
          state_o.armed         = 1'b1;
          state_o.last_cmd_time = item_i.now_ms;
          state_o.target_us     = cfg_i.pulse_min_us;
          state_o.output_us     = esc_thr_pkg::bound_pulse(cfg_i.pulse_min_us,
                                    cfg_i.pulse_min_us, cfg_i.pulse_max_us);
          result_o.pulse_written = 1'b1;
        end
      end
      esc_thr_pkg::CMD_DISARM: begin
        state_o.armed          = 1'b0;
        state_o.target_us      = cfg_i.pulse_min_us;
        state_o.output_us      = esc_thr_pkg::bound_pulse(cfg_i.pulse_min_us,
                                   cfg_i.pulse_min_us, cfg_i.pulse_max_us);
        result_o.pulse_written = 1'b1;
        result_o.pwm_stop_req  = 1'b1;
      end
      esc_thr_pkg::CMD_SET_THROTTLE: begin
        if (state_i.armed) begin
          state_o.target_us      = thr_pulse;
          state_o.last_cmd_time  = item_i.now_ms;
          state_o.output_us      = esc_thr_pkg::bound_pulse(thr_pulse,
                                     cfg_i.pulse_min_us, cfg_i.pulse_max_us);
          result_o.pulse_written = 1'b1;
        end
      end
      esc_thr_pkg::CMD_SET_PULSE: begin
        if (state_i.armed) begin
          state_o.target_us      = req_pulse;
          state_o.last_cmd_time  = item_i.now_ms;
          state_o.output_us      = esc_thr_pkg::bound_pulse(req_pulse,
                                     cfg_i.pulse_min_us, cfg_i.pulse_max_us);
          result_o.pulse_written = 1'b1;
        end
      end
      esc_thr_pkg::CMD_TICK: begin
        if (!state_i.armed) begin
          // Hold the idle pulse while disarmed.
          if (state_i.output_us != cfg_i.pulse_min_us) begin
            state_o.output_us      = esc_thr_pkg::bound_pulse(cfg_i.pulse_min_us,
                                       cfg_i.pulse_min_us, cfg_i.pulse_max_us);
            result_o.pulse_written = 1'b1;
          end
        end else if ((state_i.output_us > cfg_i.pulse_min_us) && expired) begin
          // Failsafe: command silence above idle disarms the motor.
          state_o.armed          = 1'b0;
          state_o.target_us      = cfg_i.pulse_min_us;
          state_o.output_us      = esc_thr_pkg::bound_pulse(cfg_i.pulse_min_us,
                                     cfg_i.pulse_min_us, cfg_i.pulse_max_us);
          result_o.pulse_written = 1'b1;
          result_o.pwm_stop_req  = 1'b1;
          result_o.timed_out     = 1'b1;
        end else if (state_i.output_us != state_i.target_us) begin
          state_o.output_us      = esc_thr_pkg::bound_pulse(state_i.target_us,
                                     cfg_i.pulse_min_us, cfg_i.pulse_max_us);
          result_o.pulse_written = 1'b1;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.armed_flag   = state_o.armed;
    result_o.pulse_out_us = state_o.output_us;
  end

endmodule

// ===== rtl/core/esc_throttle_arm_timeout_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ESC throttle arm and timeout controller
// Pulse-width command unit for a motor speed controller with arm control,
// linear throttle mapping and a command-timeout failsafe.
// ----------------------------------------------------------------------------
// The block accepts one item on every clock while the input side does not
// stall, and returns exactly one result for each. An accepted item is held in
// the input register until the result register is free, and then the
// controller state is updated and the result register loaded. The throttle
// multiply is done before the input register and the divide by 10000
// after it; configuration is read from the register file at both points and
// must therefore only be written while no item is in flight. The input side
// keeps taking transfers while a finished result waits, and stalls only when
// both the input and result registers are full.
// ----------------------------------------------------------------------------
module esc_throttle_arm_timeout_ctrl #(
  parameter logic [esc_thr_pkg::PulseW-1:0] PulseMinRst   = esc_thr_pkg::PulseMinRst,
  parameter logic [esc_thr_pkg::PulseW-1:0] PulseMaxRst   = esc_thr_pkg::PulseMaxRst,
  parameter logic [esc_thr_pkg::TimeW-1:0]  CmdTimeoutRst = esc_thr_pkg::CmdTimeoutRst
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [esc_thr_pkg::AddrW-1:0]  paddr,
  input  logic [esc_thr_pkg::DataW-1:0]  pwdata,
  output logic [esc_thr_pkg::DataW-1:0]  prdata,
  output logic                           pready,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [esc_thr_pkg::CmdW-1:0]   command_i,
  input  logic [esc_thr_pkg::TimeW-1:0]  now_ms_i,
  input  logic signed [esc_thr_pkg::ThrW-1:0] throttle_centipct_i,
  input  logic [esc_thr_pkg::PulseW-1:0] pulse_req_us_i,
  input  logic                           pwm_start_ok_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           armed_flag_o,
  output logic [esc_thr_pkg::PulseW-1:0] pulse_out_us_o,
  output logic                           pulse_written_o,
  output logic                           pwm_start_req_o,
  output logic                           pwm_stop_req_o,
  output logic                           timed_out_o
);

  esc_thr_pkg::cfg_t    cfg;
  esc_thr_pkg::state_t  state_q, state_d;
  esc_thr_pkg::item_t   item_q, item_d;
  esc_thr_pkg::result_t res_q, res_d;
  logic                 s1_valid_q, s1_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic                 in_xfer, s1_adv;

  logic [esc_thr_pkg::ThrCW-1:0]       thr_c;
  logic signed [esc_thr_pkg::SpanW-1:0] span;
  logic signed [esc_thr_pkg::ProdW-1:0] thr_prod;
  logic [esc_thr_pkg::NumW-1:0]         base;
  logic signed [esc_thr_pkg::SumW-1:0]  num_s;

  esc_thr_regs #(
    .PulseMinRst   (PulseMinRst),
    .PulseMaxRst   (PulseMaxRst),
    .CmdTimeoutRst (CmdTimeoutRst)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the input register moves on when the result register is free.
  assign s1_adv      = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = s1_valid_q & ~s1_adv;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = in_xfer | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & out_stall_i);

  // Throttle clamp to 0..10000 and the scaled span ahead of the input register.
  always_comb begin
    if (throttle_centipct_i[esc_thr_pkg::ThrW-1]) begin
      thr_c = '0;
    end else if (throttle_centipct_i > esc_thr_pkg::ThrW'(esc_thr_pkg::ThrFull)) begin
      thr_c = esc_thr_pkg::ThrCW'(esc_thr_pkg::ThrFull);
    end else begin
      thr_c = throttle_centipct_i[esc_thr_pkg::ThrCW-1:0];
    end
  end

  assign span     = $signed({1'b0, cfg.pulse_max_us}) - $signed({1'b0, cfg.pulse_min_us});
  assign thr_prod = esc_thr_pkg::ProdW'($signed({1'b0, thr_c}))
                    * esc_thr_pkg::ProdW'(span);
  assign base     = esc_thr_pkg::NumW'(cfg.pulse_min_us) * esc_thr_pkg::NumW'(esc_thr_pkg::ThrFull)
                    + esc_thr_pkg::NumW'(esc_thr_pkg::ThrRound);
  assign num_s    = $signed({3'b000, base}) + esc_thr_pkg::SumW'(thr_prod);

  // Input register contents.
  always_comb begin
    item_d.command      = command_i;
    item_d.now_ms       = now_ms_i;
    item_d.thr_num      = num_s[esc_thr_pkg::SumW-1] ? '0 : num_s[esc_thr_pkg::NumW-1:0];
    item_d.pulse_req_us = pulse_req_us_i;
    item_d.pwm_start_ok = pwm_start_ok_i;
  end

  esc_thr_update u_update (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Control and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q.armed         <= 1'b0;
      state_q.target_us     <= PulseMinRst;
      state_q.output_us     <= PulseMinRst;
      state_q.last_cmd_time <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign armed_flag_o    = res_q.armed_flag;
  assign pulse_out_us_o  = res_q.pulse_out_us;
  assign pulse_written_o = res_q.pulse_written;
  assign pwm_start_req_o = res_q.pwm_start_req;
  assign pwm_stop_req_o  = res_q.pwm_stop_req;
  assign timed_out_o     = res_q.timed_out;

  // The controller state only moves when an item is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(state_q))
    else $error("controller state changed without an item");

  // A reported pulse is the pulse now held in the controller state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (res_q.pulse_out_us == state_q.output_us) &&
               (res_q.armed_flag == state_q.armed))
    else $error("result does not match controller state");

  // A timeout always disarms and requests a stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.timed_out) |-> (res_q.pwm_stop_req && !res_q.armed_flag))
    else $error("timeout without disarm and stop request");

  // The input side never stalls while the input register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

endmodule
